@@ hw/rtl/msrf_pkg.sv @@
// Shared types, constants and codes for the mode shift register file.
package msrf_pkg;

    localparam int WORD_WIDTH_DEF = 32;
    localparam int WORD_COUNT     = 16;
    localparam int LANE_COUNT     = 4;
    localparam int DEST_WIDTH     = 4;
    localparam int CFG_IDX_WIDTH  = 3;
    localparam int CFG_DATA_WIDTH = 4;

    localparam logic [3:0] MASK_ALL = 4'hF;
    localparam logic [3:0] MASK_TWO = 4'h3;
    localparam logic [3:0] MASK_ONE = 4'h1;

    localparam logic [1:0] MODE_CHAIN = 2'd0;
    localparam logic [1:0] MODE_LANES = 2'd1;
    localparam logic [1:0] MODE_ADDR  = 2'd2;

    localparam logic [CFG_IDX_WIDTH-1:0] CFG_MODE  = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_DEST0 = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_DEST1 = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_DEST2 = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_DEST3 = 3'd4;

    typedef logic [2:0] cell_sel_t;
    localparam cell_sel_t SEL_HOLD   = 3'd0;
    localparam cell_sel_t SEL_SHIFT1 = 3'd1;
    localparam cell_sel_t SEL_SHIFT2 = 3'd2;
    localparam cell_sel_t SEL_SHIFT4 = 3'd3;
    localparam cell_sel_t SEL_WRITE  = 3'd4;

    typedef struct packed {
        logic      load;
        cell_sel_t sel;
    } cell_ctrl_t;

    typedef struct packed {
        logic [31:0] word_lane0;
        logic [31:0] word_lane1;
        logic [31:0] word_lane2;
        logic [31:0] word_lane3;
        logic [3:0]  lane_valid;
    } in_item_t;

    typedef struct packed {
        logic [63:0] words_0_1;
        logic [63:0] words_2_3;
        logic [63:0] words_4_5;
        logic [63:0] words_6_7;
        logic [63:0] words_8_9;
        logic [63:0] words_10_11;
        logic [63:0] words_12_13;
        logic [63:0] words_14_15;
        logic        update_valid;
    } out_item_t;

endpackage

@@ hw/rtl/msrf_cell.sv @@
// One word cell of the shift chain: holds a word, takes it from a neighbor or a lane.
module msrf_cell
    import msrf_pkg::*;
#(
    parameter int WORD_WIDTH = WORD_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cell_ctrl_t            ctrl,
    input  logic [WORD_WIDTH-1:0] src1,
    input  logic [WORD_WIDTH-1:0] src2,
    input  logic [WORD_WIDTH-1:0] src4,
    input  logic [WORD_WIDTH-1:0] wr_data,
    output logic [WORD_WIDTH-1:0] word,
    output logic [WORD_WIDTH-1:0] word_next
);

    logic [WORD_WIDTH-1:0] word_reg;

    always_comb
    begin
        unique case (ctrl.sel)
            SEL_SHIFT1: word_next = src1;
            SEL_SHIFT2: word_next = src2;
            SEL_SHIFT4: word_next = src4;
            SEL_WRITE:  word_next = wr_data;
            default:    word_next = word_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= '0;
        end
        else if (ctrl.load)
        begin
            word_reg <= word_next;
        end
    end

    assign word = word_reg;

endmodule

@@ hw/rtl/mode_shift_register_file_unit.sv @@
// Top level of the mode shift register file: cell chain, control and result buffer.
//
// Usage:
//   update channel (upd_valid/upd_ready/upd_data): one transaction carries four
//   lane words and a lane-valid mask. The sixteen word cells update in the cycle
//   the transaction is accepted, all in parallel.
//   snapshot channel (snap_valid/snap_ready/snap_data): one result per input,
//   holding all sixteen words after the update, packed in pairs, plus update_valid.
//   The result is registered in the output or skid register. Throughput is
//   one transaction per cycle while upd_ready is high; every cell loads its next
//   word from itself, its neighbors one, two or four places up, or a lane word.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready;
//   index 0 is the mode, indexes 1..4 the lane destinations, others ignored.
//   Write it only while the block is idle.
//   Reset clears all words to zero, mode to the single chain, and lane k's
//   destination to k; no results are pending.
//   When the receiver stalls, a second result is held in a skid register;
//   upd_ready drops only while both result registers are full.
module mode_shift_register_file_unit
    import msrf_pkg::*;
#(
    parameter int WORD_WIDTH = WORD_WIDTH_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      upd_valid,
    output logic                      upd_ready,
    input  in_item_t                  upd_data,
    output logic                      snap_valid,
    input  logic                      snap_ready,
    output out_item_t                 snap_data,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_WIDTH-1:0]  cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0] cfg_data
);

    logic [1:0]            mode_reg;
    logic [DEST_WIDTH-1:0] dest_reg [LANE_COUNT];

    logic [LANE_COUNT-1:0][WORD_WIDTH-1:0] lane;
    logic [WORD_COUNT-1:0][WORD_WIDTH-1:0] words;
    logic [WORD_COUNT-1:0][WORD_WIDTH-1:0] words_next;
    cell_ctrl_t                            ctrl [WORD_COUNT];
    logic [WORD_WIDTH-1:0]                 wdata [WORD_COUNT];

    logic      upd_fire;
    logic      snap_fire;
    logic      out_valid_reg;
    logic      skid_valid_reg;
    out_item_t out_reg;
    out_item_t skid_reg;
    out_item_t result;
    logic [3:0] valid_mask;

    assign valid_mask = upd_data.lane_valid;
    assign lane[0] = upd_data.word_lane0[WORD_WIDTH-1:0];
    assign lane[1] = upd_data.word_lane1[WORD_WIDTH-1:0];
    assign lane[2] = upd_data.word_lane2[WORD_WIDTH-1:0];
    assign lane[3] = upd_data.word_lane3[WORD_WIDTH-1:0];

    assign upd_ready  = !skid_valid_reg;
    assign upd_fire   = upd_valid && upd_ready;
    assign snap_valid = out_valid_reg;
    assign snap_fire  = out_valid_reg && snap_ready;
    assign snap_data  = out_reg;
    assign cfg_ready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_CHAIN;
            for (int k = 0; k < LANE_COUNT; k++)
            begin
                dest_reg[k] <= DEST_WIDTH'(k);
            end
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_MODE:  mode_reg    <= cfg_data[1:0];
                CFG_DEST0: dest_reg[0] <= cfg_data;
                CFG_DEST1: dest_reg[1] <= cfg_data;
                CFG_DEST2: dest_reg[2] <= cfg_data;
                CFG_DEST3: dest_reg[3] <= cfg_data;
                default:   ;
            endcase
        end
    end

    for (genvar g = 0; g < WORD_COUNT; g++)
    begin : g_cell
        localparam int LaneIdx = g / 4;
        localparam bit GroupTop = (g % 4) == 3;

        logic [WORD_WIDTH-1:0] src1;
        logic [WORD_WIDTH-1:0] src2;
        logic [WORD_WIDTH-1:0] src4;

        if (g < WORD_COUNT - 1)
        begin : g_s1n
            assign src1 = words[g + 1];
        end
        else
        begin : g_s1l
            assign src1 = lane[g - (WORD_COUNT - 1)];
        end

        if (g < WORD_COUNT - 2)
        begin : g_s2n
            assign src2 = words[g + 2];
        end
        else
        begin : g_s2l
            assign src2 = lane[g - (WORD_COUNT - 2)];
        end

        if (g < WORD_COUNT - 4)
        begin : g_s4n
            assign src4 = words[g + 4];
        end
        else
        begin : g_s4l
            assign src4 = lane[g - (WORD_COUNT - 4)];
        end

        always_comb
        begin
            ctrl[g].load = upd_fire;
            ctrl[g].sel  = SEL_HOLD;
            wdata[g]     = lane[LaneIdx];
            if (valid_mask != '0)
            begin
                unique case (mode_reg)
                    MODE_CHAIN:
                    begin
                        priority if (valid_mask == MASK_ALL)
                            ctrl[g].sel = SEL_SHIFT4;
                        else if (valid_mask == MASK_TWO)
                            ctrl[g].sel = SEL_SHIFT2;
                        else if (valid_mask == MASK_ONE)
                            ctrl[g].sel = SEL_SHIFT1;
                        else
                            ctrl[g].sel = SEL_HOLD;
                    end
                    MODE_LANES:
                    begin
                        if (valid_mask[LaneIdx])
                        begin
                            ctrl[g].sel = GroupTop ? SEL_WRITE : SEL_SHIFT1;
                        end
                    end
                    MODE_ADDR:
                    begin
                        // later lanes override earlier ones on the same index
                        for (int k = 0; k < LANE_COUNT; k++)
                        begin
                            if (valid_mask[k] && dest_reg[k] == DEST_WIDTH'(g))
                            begin
                                ctrl[g].sel = SEL_WRITE;
                                wdata[g]    = lane[k];
                            end
                        end
                    end
                    default: ctrl[g].sel = SEL_HOLD;
                endcase
            end
        end

        msrf_cell #(
            .WORD_WIDTH (WORD_WIDTH)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl[g]),
            .src1      (src1),
            .src2      (src2),
            .src4      (src4),
            .wr_data   (wdata[g]),
            .word      (words[g]),
            .word_next (words_next[g])
        );
    end

    always_comb
    begin
        result.words_0_1    = (64'(words_next[1])  << 32) | 64'(words_next[0]);
        result.words_2_3    = (64'(words_next[3])  << 32) | 64'(words_next[2]);
        result.words_4_5    = (64'(words_next[5])  << 32) | 64'(words_next[4]);
        result.words_6_7    = (64'(words_next[7])  << 32) | 64'(words_next[6]);
        result.words_8_9    = (64'(words_next[9])  << 32) | 64'(words_next[8]);
        result.words_10_11  = (64'(words_next[11]) << 32) | 64'(words_next[10]);
        result.words_12_13  = (64'(words_next[13]) << 32) | 64'(words_next[12]);
        result.words_14_15  = (64'(words_next[15]) << 32) | 64'(words_next[14]);
        result.update_valid = valid_mask != '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (upd_fire)
        begin
            if (!out_valid_reg || snap_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (snap_fire)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd_fire)
        begin
            if (!out_valid_reg || snap_fire)
            begin
                out_reg <= result;
            end
            else
            begin
                skid_reg <= result;
            end
        end
        else if (snap_fire && skid_valid_reg)
        begin
            out_reg <= skid_reg;
        end
    end

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a transaction while the output register is empty");

    a_empty_mask_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (upd_fire && valid_mask == '0) |=> words == $past(words))
        else $error("words changed on a transaction with no valid lane");

    a_stall_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
        (upd_fire && out_valid_reg && !snap_ready) |=> skid_valid_reg)
        else $error("transaction accepted under stall was not captured in skid");

    a_out_drops_on_take: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid_reg) |-> $past(snap_ready))
        else $error("result dropped without being taken");

endmodule

@@ tb/sv/mode_shift_register_file_unit_tb.sv @@
// Self-checking testbench for the mode shift register file: predicted word snapshots vs. results.
module mode_shift_register_file_unit_tb;
    import msrf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 60;
    localparam int HOLD_AFTER  = 250;
    localparam int PHASES      = 9;
    localparam int PHASE_ITEMS = 100;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                      upd_valid = 1'b0;
    logic                      upd_ready;
    in_item_t                  upd_data = '0;
    logic                      snap_valid;
    logic                      snap_ready = 1'b0;
    out_item_t                 snap_data;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_WIDTH-1:0]  cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0] cfg_data = '0;

    in_item_t    lane_items[$];
    out_item_t   expected_files[$];

    logic [31:0] shadow_words [WORD_COUNT];
    logic [1:0]  shadow_mode;
    logic [3:0]  shadow_dest [LANE_COUNT];

    logic        quiet = 1'b0;
    int          in_gap;
    int          out_gap;
    int          hold_left;
    logic        hold_done;
    int          results_seen;
    int          mismatches = 0;
    int          cycles = 0;

    mode_shift_register_file_unit uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .upd_valid  (upd_valid),
        .upd_ready  (upd_ready),
        .upd_data   (upd_data),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .snap_data  (snap_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #5 clk = ~clk;

    // Applies one transaction to the shadow file and returns the snapshot it produces.
    function automatic out_item_t apply_lane_update(in_item_t it);
        logic [31:0]  lane [LANE_COUNT];
        logic [31:0]  nxt [WORD_COUNT];
        logic [511:0] flat;
        out_item_t    r;
        int           by;
        int           i;
        int           k;
        lane[0] = it.word_lane0;
        lane[1] = it.word_lane1;
        lane[2] = it.word_lane2;
        lane[3] = it.word_lane3;
        nxt = shadow_words;
        if (it.lane_valid != '0)
        begin
            case (shadow_mode)
                MODE_CHAIN:
                begin
                    by = 0;
                    if (it.lane_valid == MASK_ALL)
                        by = 4;
                    else if (it.lane_valid == MASK_TWO)
                        by = 2;
                    else if (it.lane_valid == MASK_ONE)
                        by = 1;
                    for (i = 0; i + by < WORD_COUNT; i++)
                        nxt[i] = shadow_words[i + by];
                    for (i = 0; i < by; i++)
                        nxt[WORD_COUNT - by + i] = lane[i];
                end
                MODE_LANES:
                begin
                    for (k = 0; k < LANE_COUNT; k++)
                    begin
                        if (it.lane_valid[k])
                        begin
                            for (i = 0; i < 3; i++)
                                nxt[4 * k + i] = shadow_words[4 * k + i + 1];
                            nxt[4 * k + 3] = lane[k];
                        end
                    end
                end
                MODE_ADDR:
                begin
                    for (k = 0; k < LANE_COUNT; k++)
                        if (it.lane_valid[k])
                            nxt[shadow_dest[k]] = lane[k];
                end
                default:
                    ;
            endcase
        end
        shadow_words = nxt;
        for (i = 0; i < WORD_COUNT / 2; i++)
            flat[64 * (7 - i) +: 64] = {shadow_words[2 * i + 1], shadow_words[2 * i]};
        r = {flat, it.lane_valid != '0};
        return r;
    endfunction

    function automatic in_item_t lane_item(logic [31:0] w0, logic [31:0] w1,
                                           logic [31:0] w2, logic [31:0] w3,
                                           logic [3:0] mask);
        in_item_t it;
        it.word_lane0 = w0;
        it.word_lane1 = w1;
        it.word_lane2 = w2;
        it.word_lane3 = w3;
        it.lane_valid = mask;
        return it;
    endfunction

    function automatic void stage_item(in_item_t it);
        lane_items.insert(lane_items.size(), it);
    endfunction

    function automatic logic [31:0] random_word();
        int pick;
        pick = $urandom_range(0, 15);
        if (pick == 0)
            return '0;
        else if (pick == 1)
            return '1;
        return $urandom;
    endfunction

    // Chain mode only moves on full, two-lane or one-lane masks, so those dominate there.
    function automatic in_item_t random_item(logic [1:0] mode);
        logic [3:0] mask;
        int         pick;
        pick = $urandom_range(0, 9);
        if (mode == MODE_CHAIN && pick < 7)
        begin
            case ($urandom_range(0, 2))
                0: mask = MASK_ALL;
                1: mask = MASK_TWO;
                default: mask = MASK_ONE;
            endcase
        end
        else if (pick == 9)
            mask = '0;
        else
            mask = 4'($urandom_range(0, 15));
        return lane_item(random_word(), random_word(), random_word(), random_word(), mask);
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            if (mismatches < 10)
                $display("mismatch %s: expected %h, actual %h", name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_snapshot(out_item_t want, out_item_t got);
        check_field("words_0_1", want.words_0_1, got.words_0_1);
        check_field("words_2_3", want.words_2_3, got.words_2_3);
        check_field("words_4_5", want.words_4_5, got.words_4_5);
        check_field("words_6_7", want.words_6_7, got.words_6_7);
        check_field("words_8_9", want.words_8_9, got.words_8_9);
        check_field("words_10_11", want.words_10_11, got.words_10_11);
        check_field("words_12_13", want.words_12_13, got.words_12_13);
        check_field("words_14_15", want.words_14_15, got.words_14_15);
        check_field("update_valid", 64'(want.update_valid), 64'(got.update_valid));
    endtask

    task automatic write_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_MODE:  shadow_mode    = val[1:0];
            CFG_DEST0: shadow_dest[0] = val;
            CFG_DEST1: shadow_dest[1] = val;
            CFG_DEST2: shadow_dest[2] = val;
            CFG_DEST3: shadow_dest[3] = val;
            default:   ;
        endcase
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (lane_items.size() != 0 || upd_valid || expected_files.size() != 0);
        repeat (2) @(posedge clk);
    endtask

    // Driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upd_valid <= 1'b0;
            upd_data  <= '0;
            in_gap    <= 0;
        end
        else
        begin
            if (upd_valid && upd_ready)
                expected_files.insert(expected_files.size(), apply_lane_update(upd_data));
            if (!upd_valid || upd_ready)
            begin
                if (in_gap > 0)
                begin
                    in_gap    <= in_gap - 1;
                    upd_valid <= 1'b0;
                end
                else if (lane_items.size() > 0 && (quiet || $urandom_range(0, 7) != 0))
                begin
                    upd_data  <= lane_items[0];
                    lane_items.delete(0);
                    upd_valid <= 1'b1;
                end
                else if (lane_items.size() > 0)
                begin
                    in_gap    <= $urandom_range(0, 3);
                    upd_valid <= 1'b0;
                end
                else
                    upd_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
        else if (!hold_done && results_seen >= HOLD_AFTER && upd_valid)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end
    end

    // Monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_ready   <= 1'b0;
            out_gap      <= 0;
            results_seen <= 0;
        end
        else
        begin
            if (snap_valid && snap_ready)
            begin
                results_seen <= results_seen + 1;
                if (expected_files.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected transaction: %h", snap_data);
                    mismatches++;
                end
                else
                begin
                    check_snapshot(expected_files[0], snap_data);
                    expected_files.delete(0);
                end
            end
            if (hold_left > 0)
                snap_ready <= 1'b0;
            else if (out_gap > 0)
            begin
                out_gap    <= out_gap - 1;
                snap_ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                out_gap    <= $urandom_range(0, 3);
                snap_ready <= 1'b0;
            end
            else
                snap_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("mode_shift_register_file_unit regression: fail");
            $finish;
        end
    end

    initial
    begin
        int         p;
        int         k;
        int         n;
        logic [1:0] mode;
        for (k = 0; k < WORD_COUNT; k++)
            shadow_words[k] = '0;
        shadow_mode = MODE_CHAIN;
        for (k = 0; k < LANE_COUNT; k++)
            shadow_dest[k] = 4'(k);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: one chain, lane k to word k
        stage_item(lane_item('1, '1, '1, '1, MASK_ALL));
        stage_item(lane_item(32'h1, 32'h2, 32'h3, 32'h4, MASK_TWO));
        stage_item(lane_item(32'h5, 32'h6, 32'h7, 32'h8, MASK_ONE));
        stage_item(lane_item('1, '1, '1, '1, '0));
        stage_item(lane_item(32'h9, 32'ha, 32'hb, 32'hc, 4'b0101));
        stage_item(lane_item('0, '0, '0, '0, MASK_ALL));
        stage_item(lane_item(32'ha5a5a5a5, 32'h5a5a5a5a, 32'h1, 32'h80000000, 4'b0010));
        stage_item(lane_item(32'h80000000, 32'h7fffffff, 32'h1, '1, MASK_ALL));
        wait_idle();

        write_reg(CFG_MODE, {2'b00, MODE_LANES});
        for (k = 0; k < LANE_COUNT; k++)
            write_reg(CFG_DEST0 + 3'(k), '1);
        stage_item(lane_item(32'h11, 32'h22, 32'h33, 32'h44, MASK_ALL));
        stage_item(lane_item(32'h55, 32'h66, 32'h77, 32'h88, 4'b0001));
        stage_item(lane_item(32'h99, 32'haa, 32'hbb, 32'hcc, 4'b1000));
        stage_item(lane_item('1, '1, '1, '1, 4'b0110));
        stage_item(lane_item('1, '1, '1, '1, '0));
        wait_idle();

        // every lane aimed at the same word: the highest valid lane wins
        write_reg(CFG_MODE, {2'b00, MODE_ADDR});
        stage_item(lane_item(32'hdead0000, 32'hdead0001, 32'hdead0002, 32'hdead0003,
                             MASK_ALL));
        stage_item(lane_item(32'hbeef0000, 32'hbeef0001, '0, '0, MASK_TWO));
        wait_idle();
        for (k = 0; k < LANE_COUNT; k++)
            write_reg(CFG_DEST0 + 3'(k), 4'(5 * k));
        stage_item(lane_item('1, 32'h12345678, 32'h9abcdef0, '0, MASK_ALL));
        stage_item(lane_item(32'h0f0f0f0f, '0, '0, 32'hf0f0f0f0, 4'b1001));
        wait_idle();

        write_reg(CFG_MODE, {2'b00, MODE_UNUSED});
        stage_item(lane_item('1, '1, '1, '1, MASK_ALL));
        stage_item(lane_item('1, '1, '1, '1, '0));
        wait_idle();

        // writes past the last register index are dropped
        for (k = int'(CFG_DEST3) + 1; k < 2 ** CFG_IDX_WIDTH; k++)
            write_reg(CFG_IDX_WIDTH'(k), '1);
        write_reg(CFG_MODE, {2'b11, MODE_ADDR});
        stage_item(lane_item(32'h01010101, 32'h02020202, 32'h03030303, 32'h04040404,
                             MASK_ALL));
        wait_idle();

        for (p = 0; p < PHASES; p++)
        begin
            if (p < 4)
                mode = 2'(p);
            else
                mode = 2'($urandom_range(0, 2));
            write_reg(CFG_MODE, {2'($urandom_range(0, 3)), mode});
            for (k = 0; k < LANE_COUNT; k++)
            begin
                if (p == 2)
                    write_reg(CFG_DEST0 + 3'(k), '1);
                else if (p == 4)
                    write_reg(CFG_DEST0 + 3'(k), '0);
                else
                    write_reg(CFG_DEST0 + 3'(k), 4'($urandom_range(0, 15)));
            end
            if ($urandom_range(0, 2) == 0)
                write_reg(CFG_IDX_WIDTH'($urandom_range(int'(CFG_DEST3) + 1,
                                                        2 ** CFG_IDX_WIDTH - 1)),
                          4'($urandom_range(0, 15)));
            if (p == PHASES - 1)
            begin
                @(posedge clk);
                quiet <= 1'b1;
            end
            for (n = 0; n < PHASE_ITEMS; n++)
                stage_item(random_item(mode));
            wait_idle();
        end

        repeat (4) @(posedge clk);
        if (expected_files.size() != 0)
            mismatches++;
        if (mismatches == 0)
            $display("mode_shift_register_file_unit regression: pass");
        else
            $display("mode_shift_register_file_unit regression: fail");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/msrf_pkg.sv
hw/rtl/msrf_cell.sv
hw/rtl/mode_shift_register_file_unit.sv
tb/sv/mode_shift_register_file_unit_tb.sv
